// ----- rtl/core/psat_pkg.sv -----
package psat_pkg;

  localparam int MAX_VERTS   = 16;
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;

  localparam int CW    = COORD_BITS;
  localparam int EW    = CW + 1;
  localparam int PW    = 2 * CW + 1;
  localparam int DW    = PW;
  localparam int NNW   = 2 * CW + 1;
  localparam int NUMW  = DW + CW + FRAC_BITS;
  localparam int STEPW = $clog2(NUMW + 1);
  localparam int CNTW  = $clog2(MAX_VERTS + 1);
  localparam int AW    = $clog2(2 * MAX_VERTS);
  localparam int KW    = $clog2(2 * MAX_VERTS + 1);
  localparam int SW    = CW + CNTW;
  localparam int DXW   = SW + CNTW + 2;
  localparam int PUSHW = 32;
  localparam int QW    = PUSHW + 1;
  localparam int LENW  = 2 * PUSHW;
  localparam int IN_TDW  = 32;
  localparam int OUT_TDW = 72;

  localparam logic [PUSHW-1:0] PUSH_CAP = {1'b1, {(PUSHW-1){1'b0}}};
  localparam logic [PUSHW-1:0] PUSH_MAX = {1'b0, {(PUSHW-1){1'b1}}};

endpackage

// ----- rtl/core/psat_div.sv -----
module psat_div import psat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUMW-1:0]  num_i,
  input  logic [NNW-1:0]   den_i,
  output logic             done_o,
  output logic [PUSHW-1:0] mag_o
);

  logic             run_q;
  logic             done_q;
  logic [STEPW-1:0] step_q;
  logic [NUMW-1:0]  num_q;
  logic [NNW-1:0]   den_q;
  logic [NNW-1:0]   rem_q;
  logic [QW-1:0]    quo_q;
  logic             sat_q;

  logic [NNW:0]     trial;
  logic             ge;
  logic [NNW:0]     diff;

  assign trial = {rem_q, num_q[NUMW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEPW'(NUMW);
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        sat_q  <= 1'b0;
      end else if (run_q) begin
        rem_q  <= ge ? diff[NNW-1:0] : trial[NNW-1:0];
        quo_q  <= {quo_q[QW-2:0], ge};
        sat_q  <= sat_q | quo_q[QW-1];
        num_q  <= {num_q[NUMW-2:0], 1'b0};
        step_q <= step_q - 1'b1;
        if (step_q == STEPW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign mag_o  = (sat_q || quo_q > {1'b0, PUSH_CAP}) ? PUSH_CAP : quo_q[PUSHW-1:0];

endmodule

// ----- rtl/core/polygon_sat_collision.sv -----
// Separating-axis collision test for two convex polygons with minimum push.
// Input stream: one vertex per transfer, tdata = {vert_y, vert_x}; tlast
// closes a polygon. The first tlast closes polygon one, the second closes
// polygon two and starts the test. Up to MAX_VERTS vertices per polygon are
// kept; extra ones are dropped and flag overflow.
// Output stream: one transfer per polygon pair with collide, push_x, push_y
// (Q16.16, saturating) and overflow.
// Vertices are accepted back to back while loading; during the test tready
// is low. Each axis projects both polygons through the vertex memory, then
// the bit-serial divider (NUMW=65) forms the two push components, then the
// push length is compared; the centroid check follows the last axis. A
// separating axis ends the test early and a zero-length axis skips the
// divider.
// The result sits in an output register; vertices of the next pair are taken
// while it waits. If the receiver still stalls when the next test ends, the
// block holds in its output state until the register frees.
// Reset clears counts and flags; the vertex memory needs no clearing.
module polygon_sat_collision import psat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [15:0] vert_x, [31:16] vert_y
  input  logic [IN_TDW-1:0]  s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [0] collide, [32:1] push_x, [64:33] push_y, [65] overflow, rest zero
  output logic [OUT_TDW-1:0] m_axis_tdata_o
);

  typedef enum logic [4:0] {
    ST_LOAD, ST_EA, ST_EB, ST_EC, ST_PRJ, ST_CHK, ST_NN, ST_MUL, ST_DIVS,
    ST_DIV, ST_LEN1, ST_LEN2, ST_NEXT, ST_CEN1, ST_CEN2, ST_DOT1, ST_DOT2,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [2*CW-1:0] mem [2*MAX_VERTS];
  logic [2*CW-1:0] rdata_q;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;

  logic [CNTW-1:0] cnt0_q, cnt1_q, idx_q;
  logic            second_q, ovf_q, pol_q, comp_q, have_q;
  logic signed [SW-1:0] s0x_q, s0y_q, s1x_q, s1y_q;
  logic signed [CW-1:0] xi_q, yi_q;
  logic signed [EW-1:0] nx_q, ny_q;
  logic [KW-1:0]   k_q;
  logic            v1_q, v2_q, pol1_q, pol2_q, first1_q, first2_q;
  logic signed [PW-1:0] prx_q, pry_q;
  logic signed [PW-1:0] mn_q [2];
  logic signed [PW-1:0] mx_q [2];
  logic [NNW-1:0]  nn_q;
  logic [DW-1:0]   d_q;
  logic [NUMW-1:0] num_q;
  logic signed [PUSHW-1:0] px_q, py_q, bx_q, by_q;
  logic [PUSHW-1:0] ax_q, ay_q;
  logic [LENW-1:0] sq_q, best_q;
  logic signed [DXW-1:0] dx_q, dy_q;
  logic signed [DXW+PUSHW-1:0] t_q;
  logic            res_col_q;
  logic signed [PUSHW-1:0] res_px_q, res_py_q;
  logic            out_valid_q;
  logic [OUT_TDW-1:0] out_data_q;

  logic            div_start, div_done;
  logic [PUSHW-1:0] div_mag;

  logic            s_acc, full;
  logic [CNTW-1:0] load_cnt, cur_cnt, idx_nx, jdx;
  logic [AW-1:0]   pbase;
  logic signed [CW-1:0] rx, ry;
  logic signed [PW:0] psum;
  logic signed [PW-1:0] pval;
  logic [KW-1:0]   tot;
  logic signed [2*EW:0] nnsum;
  logic signed [PW:0] da, db;
  logic [CW-1:0]   anx, any;
  logic            neg;
  logic [PUSHW-1:0] mag_cl;
  logic [LENW-1:0] len;
  logic signed [DXW+PUSHW:0] dot;

  psat_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (nn_q),
    .done_o  (div_done),
    .mag_o   (div_mag)
  );

  assign s_axis_tready_o = state_q == ST_LOAD;
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_cnt = second_q ? cnt1_q : cnt0_q;
  assign full     = load_cnt == CNTW'(MAX_VERTS);
  assign mem_we   = s_acc && !full;
  assign wr_addr  = (second_q ? AW'(MAX_VERTS) : AW'(0)) + AW'(load_cnt);

  assign cur_cnt  = pol_q ? cnt1_q : cnt0_q;
  assign idx_nx   = idx_q + 1'b1;
  assign jdx      = (idx_nx == cur_cnt) ? '0 : idx_nx;
  assign pbase    = pol_q ? AW'(MAX_VERTS) : AW'(0);
  assign tot      = KW'(cnt0_q) + KW'(cnt1_q);

  assign rx = rdata_q[CW-1:0];
  assign ry = rdata_q[2*CW-1:CW];
  assign psum = prx_q + pry_q;
  assign pval = psum[PW-1:0];
  assign nnsum = nx_q * nx_q + ny_q * ny_q;
  assign da = mx_q[1] - mn_q[0];
  assign db = mx_q[0] - mn_q[1];
  assign anx = nx_q[EW-1] ? CW'(-nx_q) : CW'(nx_q);
  assign any = ny_q[EW-1] ? CW'(-ny_q) : CW'(ny_q);
  assign neg = comp_q ? ny_q[EW-1] : nx_q[EW-1];
  assign mag_cl = (div_mag > PUSH_MAX) ? PUSH_MAX : div_mag;
  assign len = sq_q + LENW'(ay_q) * LENW'(ay_q);
  assign dot = t_q + dy_q * by_q;
  assign div_start = state_q == ST_DIVS;

  always_comb begin
    rd_addr = '0;
    case (state_q)
      ST_EA:   rd_addr = pbase + AW'(idx_q);
      ST_EB:   rd_addr = pbase + AW'(jdx);
      ST_PRJ:  rd_addr = (k_q < KW'(cnt0_q)) ? AW'(k_q)
                                             : AW'(MAX_VERTS) + AW'(k_q - KW'(cnt0_q));
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= {s_axis_tdata_i[16+CW-1:16], s_axis_tdata_i[CW-1:0]};
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt0_q <= '0; cnt1_q <= '0; idx_q <= '0;
      second_q <= 1'b0; ovf_q <= 1'b0; pol_q <= 1'b0; comp_q <= 1'b0; have_q <= 1'b0;
      s0x_q <= '0; s0y_q <= '0; s1x_q <= '0; s1y_q <= '0;
      xi_q <= '0; yi_q <= '0; nx_q <= '0; ny_q <= '0;
      k_q <= '0; v1_q <= 1'b0; v2_q <= 1'b0;
      pol1_q <= 1'b0; pol2_q <= 1'b0; first1_q <= 1'b0; first2_q <= 1'b0;
      prx_q <= '0; pry_q <= '0;
      mn_q[0] <= '0; mn_q[1] <= '0; mx_q[0] <= '0; mx_q[1] <= '0;
      nn_q <= '0; d_q <= '0; num_q <= '0;
      px_q <= '0; py_q <= '0; bx_q <= '0; by_q <= '0; ax_q <= '0; ay_q <= '0;
      sq_q <= '0; best_q <= '0; dx_q <= '0; dy_q <= '0; t_q <= '0;
      res_col_q <= 1'b0; res_px_q <= '0; res_py_q <= '0;
      out_valid_q <= 1'b0; out_data_q <= '0;
    end else begin
      if (m_axis_tready_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (s_acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else if (second_q) begin
              cnt1_q <= cnt1_q + 1'b1;
              s1x_q  <= s1x_q + SW'($signed(s_axis_tdata_i[CW-1:0]));
              s1y_q  <= s1y_q + SW'($signed(s_axis_tdata_i[16+CW-1:16]));
            end else begin
              cnt0_q <= cnt0_q + 1'b1;
              s0x_q  <= s0x_q + SW'($signed(s_axis_tdata_i[CW-1:0]));
              s0y_q  <= s0y_q + SW'($signed(s_axis_tdata_i[16+CW-1:16]));
            end
            if (s_axis_tlast_i) begin
              if (!second_q) begin
                second_q <= 1'b1;
              end else begin
                pol_q   <= 1'b0;
                idx_q   <= '0;
                have_q  <= 1'b0;
                state_q <= ST_EA;
              end
            end
          end
        end
        ST_EA: state_q <= ST_EB;
        ST_EB: begin
          xi_q    <= rx;
          yi_q    <= ry;
          state_q <= ST_EC;
        end
        ST_EC: begin
          nx_q    <= EW'(ry) - EW'(yi_q);
          ny_q    <= EW'(xi_q) - EW'(rx);
          k_q     <= '0;
          v1_q    <= 1'b0;
          v2_q    <= 1'b0;
          state_q <= ST_PRJ;
        end
        ST_PRJ: begin
          if (k_q < tot) begin
            v1_q     <= 1'b1;
            pol1_q   <= k_q >= KW'(cnt0_q);
            first1_q <= (k_q == '0) || (k_q == KW'(cnt0_q));
            k_q      <= k_q + 1'b1;
          end else begin
            v1_q <= 1'b0;
          end
          v2_q     <= v1_q;
          pol2_q   <= pol1_q;
          first2_q <= first1_q;
          prx_q    <= rx * nx_q;
          pry_q    <= ry * ny_q;
          if (v2_q) begin
            if (first2_q || pval < mn_q[pol2_q]) mn_q[pol2_q] <= pval;
            if (first2_q || pval > mx_q[pol2_q]) mx_q[pol2_q] <= pval;
          end
          if (k_q == tot && !v1_q && !v2_q) state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (!(mx_q[0] >= mn_q[1] && mx_q[1] >= mn_q[0])) begin
            res_col_q <= 1'b0;
            res_px_q  <= '0;
            res_py_q  <= '0;
            state_q   <= ST_OUT;
          end else begin
            nn_q    <= NNW'(nnsum);
            d_q     <= (da < db) ? DW'(da) : DW'(db);
            comp_q  <= 1'b0;
            state_q <= ST_NN;
          end
        end
        ST_NN: state_q <= (nn_q == '0) ? ST_NEXT : ST_MUL;
        ST_MUL: begin
          num_q   <= {(DW+CW)'(d_q) * (DW+CW)'(comp_q ? any : anx), {FRAC_BITS{1'b0}}};
          state_q <= ST_DIVS;
        end
        ST_DIVS: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            if (!comp_q) begin
              px_q    <= neg ? -$signed(div_mag) : $signed(mag_cl);
              ax_q    <= neg ? div_mag : mag_cl;
              comp_q  <= 1'b1;
              state_q <= ST_MUL;
            end else begin
              py_q    <= neg ? -$signed(div_mag) : $signed(mag_cl);
              ay_q    <= neg ? div_mag : mag_cl;
              state_q <= ST_LEN1;
            end
          end
        end
        ST_LEN1: begin
          sq_q    <= LENW'(ax_q) * LENW'(ax_q);
          state_q <= ST_LEN2;
        end
        ST_LEN2: begin
          if (!have_q || len < best_q) begin
            have_q <= 1'b1;
            best_q <= len;
            bx_q   <= px_q;
            by_q   <= py_q;
          end
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          if (idx_nx == cur_cnt) begin
            idx_q <= '0;
            if (!pol_q) begin
              pol_q   <= 1'b1;
              state_q <= ST_EA;
            end else begin
              state_q <= ST_CEN1;
            end
          end else begin
            idx_q   <= idx_nx;
            state_q <= ST_EA;
          end
        end
        ST_CEN1: begin
          if (!have_q) begin
            res_col_q <= 1'b1;
            res_px_q  <= '0;
            res_py_q  <= '0;
            state_q   <= ST_OUT;
          end else begin
            dx_q    <= s0x_q * $signed({1'b0, cnt1_q}) - s1x_q * $signed({1'b0, cnt0_q});
            state_q <= ST_CEN2;
          end
        end
        ST_CEN2: begin
          dy_q    <= s0y_q * $signed({1'b0, cnt1_q}) - s1y_q * $signed({1'b0, cnt0_q});
          state_q <= ST_DOT1;
        end
        ST_DOT1: begin
          t_q     <= dx_q * bx_q;
          state_q <= ST_DOT2;
        end
        ST_DOT2: begin
          res_col_q <= 1'b1;
          if (dot > 0) begin
            res_px_q <= ($unsigned(bx_q) == PUSH_CAP) ? $signed(PUSH_MAX) : -bx_q;
            res_py_q <= ($unsigned(by_q) == PUSH_CAP) ? $signed(PUSH_MAX) : -by_q;
          end else begin
            res_px_q <= bx_q;
            res_py_q <= by_q;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{(OUT_TDW-2*PUSHW-2){1'b0}}, ovf_q, res_py_q, res_px_q, res_col_q};
            cnt0_q   <= '0;
            cnt1_q   <= '0;
            second_q <= 1'b0;
            ovf_q    <= 1'b0;
            s0x_q <= '0; s0y_q <= '0; s1x_q <= '0; s1y_q <= '0;
            state_q  <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_test_has_verts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (cnt0_q != '0 && cnt1_q != '0))
    else $error("test running on an empty polygon");

  a_edge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EA) |-> (idx_q < cur_cnt))
    else $error("edge index past vertex count");

  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_out_from_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_OUT))
    else $error("result raised without a finished test");

endmodule

// ----- dv/polygon_sat_collision_test.sv -----
module polygon_sat_collision_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psat_pkg::*;

  typedef struct {
    bit          collide;
    logic [31:0] push_x;
    logic [31:0] push_y;
    bit          overflow;
  } sat_result_t;

  class sat_scoreboard;
    int          vx[2][MAX_VERTS];
    int          vy[2][MAX_VERTS];
    int          cnt[2];
    bit          second;
    bit          ovf;
    sat_result_t result_q[$];
    int          errors;

    function int pending();
      return result_q.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    function void project(int p, longint nx, longint ny, output longint mn,
                          output longint mx);
      longint v;
      for (int i = 0; i < cnt[p]; i++) begin
        v = longint'(vx[p][i]) * nx + longint'(vy[p][i]) * ny;
        if (i == 0 || v < mn) mn = v;
        if (i == 0 || v > mx) mx = v;
      end
    endfunction

    function longint push_comp(longint d, longint n, longint unsigned nn);
      logic [127:0] num;
      logic [127:0] q;
      longint unsigned an;
      an = n < 0 ? longint'(-n) : longint'(n);
      num = 128'(d) * 128'(an);
      num = num << 16;
      q = num / 128'(nn);
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      if (n < 0) return -longint'(q[63:0]);
      if (q > 128'h7fff_ffff) return 64'sh7fff_ffff;
      return longint'(q[63:0]);
    endfunction

    function sat_result_t run_sat();
      sat_result_t r;
      longint nx, ny, mn1, mx1, mn2, mx2, d, px, py, bx, by;
      longint s1x, s1y, s2x, s2y, dx, dy;
      longint unsigned nn, len, best;
      bit have;
      int j;
      r.collide = 0;
      r.push_x = '0;
      r.push_y = '0;
      r.overflow = ovf;
      have = 0;
      best = 0;
      bx = 0;
      by = 0;
      for (int p = 0; p < 2; p++) begin
        for (int i = 0; i < cnt[p]; i++) begin
          j = (i + 1 == cnt[p]) ? 0 : i + 1;
          nx = longint'(vy[p][j]) - vy[p][i];
          ny = -(longint'(vx[p][j]) - vx[p][i]);
          project(0, nx, ny, mn1, mx1);
          project(1, nx, ny, mn2, mx2);
          if (!(mx1 >= mn2 && mx2 >= mn1)) return r;
          nn = nx * nx + ny * ny;
          if (nn == 0) continue;
          d = (mx2 - mn1 < mx1 - mn2) ? mx2 - mn1 : mx1 - mn2;
          px = push_comp(d, nx, nn);
          py = push_comp(d, ny, nn);
          len = longint'(px * px) + longint'(py * py);
          if (!have || len < best) begin
            have = 1;
            best = len;
            bx = px;
            by = py;
          end
        end
      end
      r.collide = 1;
      if (!have) return r;
      s1x = 0; s1y = 0; s2x = 0; s2y = 0;
      for (int i = 0; i < cnt[0]; i++) begin
        s1x += vx[0][i];
        s1y += vy[0][i];
      end
      for (int i = 0; i < cnt[1]; i++) begin
        s2x += vx[1][i];
        s2y += vy[1][i];
      end
      dx = s1x * cnt[1] - s2x * cnt[0];
      dy = s1y * cnt[1] - s2y * cnt[0];
      if (dx * bx + dy * by > 0) begin
        bx = (bx == -64'sh8000_0000) ? 64'sh7fff_ffff : -bx;
        by = (by == -64'sh8000_0000) ? 64'sh7fff_ffff : -by;
      end
      r.push_x = bx[31:0];
      r.push_y = by[31:0];
      return r;
    endfunction

    function void note_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
      int p;
      p = second;
      if (cnt[p] < MAX_VERTS) begin
        vx[p][cnt[p]] = x;
        vy[p][cnt[p]] = y;
        cnt[p]++;
      end else begin
        ovf = 1;
      end
      if (!last) return;
      if (!second) begin
        second = 1;
        return;
      end
      result_q.insert(result_q.size(), run_sat());
      cnt[0] = 0;
      cnt[1] = 0;
      second = 0;
      ovf = 0;
    endfunction

    task check(logic [OUT_TDW-1:0] td);
      sat_result_t e;
      if (result_q.size() == 0) begin
        report("unexpected transfer", td[32:1], '0);
        return;
      end
      e = result_q.pop_front();
      if (td[0] != e.collide) report("collide", 32'(td[0]), 32'(e.collide));
      if (td[32:1] != e.push_x) report("push_x", td[32:1], e.push_x);
      if (td[64:33] != e.push_y) report("push_y", td[64:33], e.push_y);
      if (td[65] != e.overflow) report("overflow", 32'(td[65]), 32'(e.overflow));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_TDW-1:0]   s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_TDW-1:0]  m_axis_tdata;

  sat_scoreboard sb;
  int  snd_idle;
  int  rcv_idle;
  bit  hold_req;
  int  vertices_sent;

  polygon_sat_collision u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("polygon_sat_collision_test: errors");
    $finish;
  end

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  task automatic send_vertex(int x, int y, bit last);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {16'(y), 16'(x)};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vertex(16'(x), 16'(y), last);
    vertices_sent++;
  endtask

  task automatic send_convex(int n, int cx, int cy, int r);
    real a;
    for (int i = 0; i < n; i++) begin
      a = 6.283185307 * (i + 0.3 * ($urandom_range(100) / 100.0)) / n;
      send_vertex(clamp16(cx + longint'($rtoi(r * $cos(a)))),
                  clamp16(cy + longint'($rtoi(r * $sin(a)))), i == n - 1);
    end
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++)
      send_vertex($signed(16'($urandom)), $signed(16'($urandom)), i == n - 1);
  endtask

  task automatic send_random_pair();
    int kind, n1, n2, cx, cy, r1, r2;
    kind = $urandom_range(19);
    n1 = $urandom_range(3, 6);
    n2 = $urandom_range(3, 6);
    if ($urandom_range(9) == 0) n1 = $urandom_range(1, 2);
    cx = $urandom_range(4000) - 2000;
    cy = $urandom_range(4000) - 2000;
    r1 = $urandom_range(1, 400);
    r2 = $urandom_range(1, 400);
    if (kind < 2) begin
      send_noise($urandom_range(1, 5));
      send_noise($urandom_range(1, 5));
    end else if (kind == 2) begin
      send_convex($urandom_range(MAX_VERTS + 1, MAX_VERTS + 2), cx, cy, r1);
      send_convex(n2, cx, cy, r2);
    end else if (kind == 3) begin
      send_convex(n1, cx, cy, r1);
      send_convex($urandom_range(MAX_VERTS - 1, MAX_VERTS + 1), cx + 10, cy, r2);
    end else if (kind == 4) begin
      send_convex(n1, 0, 0, 20000);
      send_convex(n2, $urandom_range(20000) - 10000, 0, 20000);
    end else begin
      send_convex(n1, cx, cy, r1);
      send_convex(n2, cx + int'($urandom_range(2 * (r1 + r2))) - (r1 + r2),
                  cy + int'($urandom_range(2 * (r1 + r2))) - (r1 + r2), r2);
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  initial begin
    int target;
    sb = new();
    snd_idle = 0;
    rcv_idle = 0;
    hold_req = 1'b0;
    vertices_sent = 0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // triangles that touch at a single point
    send_vertex(0, 0, 0); send_vertex(10, 0, 0); send_vertex(0, 10, 1);
    send_vertex(5, 5, 0); send_vertex(15, 5, 0); send_vertex(5, 15, 1);
    // single points: zero-length axes only
    send_vertex(7, 7, 1); send_vertex(7, 7, 1);
    // coordinate extremes, saturating push
    send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
    send_vertex(32767, 32767, 1);
    send_vertex(-32768, 32767, 0); send_vertex(0, 0, 1);
    // separated
    send_vertex(0, 0, 0); send_vertex(1, 0, 0); send_vertex(0, 1, 1);
    send_vertex(100, 100, 0); send_vertex(101, 100, 0); send_vertex(100, 101, 1);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 20 : (ph == 1) ? 67 : 0;
      rcv_idle = (ph == 0) ? 67 : (ph == 1) ? 20 : 0;
      if (ph == 0) hold_req = 1'b1;
      target = vertices_sent + 250;
      while (vertices_sent < target) send_random_pair();
      if (ph == 1) begin
        s_axis_tvalid <= 1'b0;
        drain();
      end
    end

    s_axis_tvalid <= 1'b0;
    drain();
    repeat (6000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("polygon_sat_collision_test: clean");
    end else begin
      $display("polygon_sat_collision_test: errors");
    end
    $finish;
  end

endmodule

// ----- polygon_sat_collision.f -----
rtl/core/psat_pkg.sv
rtl/core/psat_div.sv
rtl/core/polygon_sat_collision.sv
dv/polygon_sat_collision_test.sv
